### rtl/core/bct_pkg.sv
// Shared types and constants for the Bezier curve tessellator.
// Used by bct_front, bct_queue, bct_back and bezier_curve_tessellator_top.
package bct_pkg;

	localparam int COORD_W    = 16;
	localparam int NUM_COORDS = 12;
	localparam int SEG_W      = 6;
	localparam int T_W        = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int IN_DATA_W  = COORD_W * NUM_COORDS;
	localparam int OUT_DATA_W = 56;

	localparam logic [COORD_W-1:0] COORD_SIGN = 16'h8000;
	localparam logic [T_W-1:0]     ONE_Q16    = 17'h10000;
	localparam logic [SEG_W-1:0]   SEG_RESET  = 6'd60;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_ORDER = 2'd1;

	localparam logic ORDER_QUAD  = 1'b0;
	localparam logic ORDER_CUBIC = 1'b1;

	// one curve, classified: offset-binary coordinates plus the Q1.16 step
	typedef struct packed {
		logic [NUM_COORDS-1:0][COORD_W-1:0] pts;
		logic                               order;
		logic [SEG_W-1:0]                   seg;
		logic [T_W-1:0]                     quo;
		logic [SEG_W-1:0]                   rem;
	} job_t;

endpackage

### rtl/core/bct_front.sv
// Front end: configuration registers, input beat acceptance and step computation
// (65536 / segments by restoring division). Depends on bct_pkg.
module bct_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bct_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bct_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bct_pkg::IN_DATA_W-1:0]     in_data,
	output logic                              push_valid,
	input  logic                              push_ready,
	output bct_pkg::job_t                     push_data
);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

	fstate_t                      state_q;
	logic [bct_pkg::SEG_W-1:0]    segments_q;
	logic                         order_q;
	bct_pkg::job_t                job_q;
	logic [4:0]                   cnt_q;

	logic [bct_pkg::SEG_W:0]      trial;
	logic                         ge;
	logic [bct_pkg::SEG_W:0]      diff;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_data  = job_q;

	// the dividend 2^16 has its only set bit on the first step
	assign trial = {job_q.rem, (cnt_q == 5'd16)};
	assign ge    = (trial >= {1'b0, job_q.seg});
	assign diff  = trial - {1'b0, job_q.seg};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segments_q <= bct_pkg::SEG_RESET;
			order_q    <= bct_pkg::ORDER_QUAD;
		end else if (cfg_valid) begin
			case (cfg_index)
				bct_pkg::REG_SEGMENTS:    segments_q <= cfg_data;
				bct_pkg::REG_CURVE_ORDER: order_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= 5'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_DIV;
						cnt_q   <= 5'd16;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			for (int k = 0; k < bct_pkg::NUM_COORDS; k++) begin
				job_q.pts[k] <= in_data[k*bct_pkg::COORD_W +: bct_pkg::COORD_W]
					^ bct_pkg::COORD_SIGN;
			end
			job_q.order <= order_q;
			job_q.seg   <= (segments_q == '0) ? bct_pkg::SEG_W'(1) : segments_q;
			job_q.quo   <= '0;
			job_q.rem   <= '0;
		end else if (state_q == F_DIV) begin
			job_q.quo <= {job_q.quo[bct_pkg::T_W-2:0], ge};
			job_q.rem <= ge ? diff[bct_pkg::SEG_W-1:0] : trial[bct_pkg::SEG_W-1:0];
		end
	end

endmodule

### rtl/core/bct_queue.sv
// Two-entry queue of classified curves between front and back end.
// Depends on bct_pkg for the entry type.
module bct_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bct_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bct_pkg::job_t pop_data
);

	bct_pkg::job_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/core/bct_back.sv
// Back end: point sequencer (t by quotient/remainder stepping) and a six-stage
// weight and blend pipeline whose last stage is the output register. Depends on bct_pkg.
module bct_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_valid,
	output logic                                job_ready,
	input  bct_pkg::job_t                       job_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bct_pkg::NUM_COORDS/4-1:0][bct_pkg::COORD_W-1:0] out_coord,
	output logic [bct_pkg::SEG_W-1:0]           out_number,
	output logic                                out_last
);

	localparam int W_W  = 49;
	localparam int P_W  = 33;
	localparam int WL_W = 32;
	localparam int WH_W = W_W - WL_W;
	localparam int NC   = 3;
	localparam int NP   = 4;
	localparam logic [63:0] HALF = 64'h0000_8000_0000_0000;

	typedef logic [bct_pkg::NUM_COORDS-1:0][bct_pkg::COORD_W-1:0] pts_t;

	// sequencer
	logic                        active_q;
	bct_pkg::job_t               cur_q;
	logic [bct_pkg::SEG_W-1:0]   i_q;
	logic [bct_pkg::T_W-1:0]     t_q;
	logic [bct_pkg::SEG_W-1:0]   r_q;
	logic                        adv;
	logic                        last_now;
	logic [bct_pkg::SEG_W:0]     rsum;
	logic                        carry;

	// pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [bct_pkg::T_W-1:0] t_s1, s_s1, t_s2, s_s2;
	logic [P_W-1:0] ss_s2, st_s2, tt_s2;
	logic [bct_pkg::T_W:0] s3x_s2, t3x_s2;
	logic [NP-1:0][W_W-1:0] w_s3;
	logic [NC-1:0][NP-1:0][47:0] pl_s4;
	logic [NC-1:0][NP-1:0][WH_W+bct_pkg::COORD_W-1:0] ph_s4;
	logic [NC-1:0][49:0] sl_s5;
	logic [NC-1:0][34:0] sh_s5;
	pts_t pts_s1, pts_s2, pts_s3;
	logic order_s1, order_s2;
	logic [bct_pkg::SEG_W-1:0] num_s1, num_s2, num_s3, num_s4, num_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;

	logic [49:0] m_sss;
	logic [50:0] m_sst;
	logic [50:0] m_stt;
	logic [49:0] m_ttt;

	assign adv       = !v_s6 || out_ready;
	assign last_now  = (i_q == cur_q.seg);
	assign job_ready = !active_q || (adv && last_now);
	assign rsum      = {1'b0, r_q} + {1'b0, cur_q.rem};
	assign carry     = (rsum >= {1'b0, cur_q.seg});
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			i_q      <= '0;
			t_q      <= '0;
			r_q      <= '0;
		end else if (job_valid && job_ready) begin
			active_q <= 1'b1;
			i_q      <= '0;
			t_q      <= '0;
			r_q      <= '0;
		end else if (active_q && adv) begin
			if (last_now) begin
				active_q <= 1'b0;
			end
			i_q <= i_q + bct_pkg::SEG_W'(1);
			// step t by floor(65536/seg), one more when the remainder wraps
			t_q <= t_q + cur_q.quo + bct_pkg::T_W'(carry);
			r_q <= carry ? bct_pkg::SEG_W'(rsum - {1'b0, cur_q.seg})
				: rsum[bct_pkg::SEG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			cur_q <= job_data;
		end
	end

	// valid chain: the whole pipe holds while the output beat waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= active_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign m_sss = ss_s2 * s_s2;
	assign m_sst = st_s2 * s3x_s2;
	assign m_stt = st_s2 * t3x_s2;
	assign m_ttt = tt_s2 * t_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: issue one point
			t_s1     <= t_q;
			s_s1     <= bct_pkg::ONE_Q16 - t_q;
			pts_s1   <= cur_q.pts;
			order_s1 <= cur_q.order;
			num_s1   <= i_q;
			last_s1  <= last_now;

			// s2: second-degree terms
			ss_s2    <= P_W'(s_s1 * s_s1);
			st_s2    <= P_W'(s_s1 * t_s1);
			tt_s2    <= P_W'(t_s1 * t_s1);
			s3x_s2   <= {1'b0, s_s1} + {s_s1, 1'b0};
			t3x_s2   <= {1'b0, t_s1} + {t_s1, 1'b0};
			t_s2     <= t_s1;
			s_s2     <= s_s1;
			pts_s2   <= pts_s1;
			order_s2 <= order_s1;
			num_s2   <= num_s1;
			last_s2  <= last_s1;

			// s3: Bernstein weights scaled to 2^48
			if (order_s2 == bct_pkg::ORDER_CUBIC) begin
				w_s3[0] <= m_sss[W_W-1:0];
				w_s3[1] <= m_sst[W_W-1:0];
				w_s3[2] <= m_stt[W_W-1:0];
				w_s3[3] <= m_ttt[W_W-1:0];
			end else begin
				w_s3[0] <= {ss_s2, 16'h0000};
				w_s3[1] <= {st_s2[31:0], 17'h00000};
				w_s3[2] <= '0;
				w_s3[3] <= {tt_s2, 16'h0000};
			end
			pts_s3  <= pts_s2;
			num_s3  <= num_s2;
			last_s3 <= last_s2;

			// s4: weight times coordinate, weight split in low and high parts
			for (int c = 0; c < NC; c++) begin
				for (int p = 0; p < NP; p++) begin
					pl_s4[c][p] <= w_s3[p][WL_W-1:0] * pts_s3[p*NC+c];
					ph_s4[c][p] <= w_s3[p][W_W-1:WL_W] * pts_s3[p*NC+c];
				end
			end
			num_s4  <= num_s3;
			last_s4 <= last_s3;

			// s5: sum the partial products
			for (int c = 0; c < NC; c++) begin
				sl_s5[c] <= 50'(pl_s4[c][0]) + 50'(pl_s4[c][1])
					+ 50'(pl_s4[c][2]) + 50'(pl_s4[c][3]);
				sh_s5[c] <= 35'(ph_s4[c][0]) + 35'(ph_s4[c][1])
					+ 35'(ph_s4[c][2]) + 35'(ph_s4[c][3]);
			end
			num_s5  <= num_s4;
			last_s5 <= last_s4;

			// s6: round half up, drop 48 fraction bits, back to two's complement
			for (int c = 0; c < NC; c++) begin
				out_coord[c] <= 16'(({sh_s5[c][31:0], 32'h0000_0000} + 64'(sl_s5[c])
					+ HALF) >> 48) ^ bct_pkg::COORD_SIGN;
			end
			out_number <= num_s5;
			out_last   <= last_s5;
		end
	end

endmodule

### rtl/core/bezier_curve_tessellator_top.sv
// Bezier curve tessellator: one curve beat in, segments+1 point beats out (two when segments is zero).
// Throughput: one point per cycle while the output is ready and a classified curve waits in the queue;
// the front divider works out the step of the next curve while the back pipeline emits points.
// Reset clears all control state and sets segments to 60 and curve order to quadratic.
module bezier_curve_tessellator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// start_x/y/z, ctrl_a_x/y/z, ctrl_b_x/y/z, finish_x/y/z, 16 bits each
	input  logic [bct_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// point_x, point_y, point_z (16 bits each), point_number (6), 2 pad bits
	output logic [bct_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bct_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bct_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic                                       push_valid;
	logic                                       push_ready;
	bct_pkg::job_t                              push_data;
	logic                                       pop_valid;
	logic                                       pop_ready;
	bct_pkg::job_t                              pop_data;
	logic [2:0][bct_pkg::COORD_W-1:0]           coord;
	logic [bct_pkg::SEG_W-1:0]                  number;

	bct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (pop_valid),
		.job_ready  (pop_ready),
		.job_data   (pop_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_coord  (coord),
		.out_number (number),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, number, coord[2], coord[1], coord[0]};

endmodule

### sim/bezier_curve_tessellator_checker.sv
// Point checker for the Bezier curve tessellator: tracks register writes, predicts the
// point beats of every accepted curve and compares them with the output stream.
// Depends on bct_pkg for widths, register indexes and curve order codes.
module bezier_curve_tessellator_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [bct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic                           m_axis_tlast,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [bct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bct_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import bct_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [SEG_W-1:0]   num;
		logic               last;
	} point_t;

	logic [SEG_W-1:0] seg_setting;
	logic             order_setting;
	point_t           points_due[$];
	int               bad_points;

	// Exact weighted sum in offset binary, rounded half up.
	function automatic logic [COORD_W-1:0] blend_coord(
		input logic [COORD_W-1:0] p0,
		input logic [COORD_W-1:0] p1,
		input logic [COORD_W-1:0] p2,
		input logic [COORD_W-1:0] p3,
		input logic [T_W-1:0]     t,
		input logic               cubic
	);
		logic [T_W-1:0]     s;
		logic [95:0]        v0, v1, v2, v3, sw, tw, acc;
		s  = ONE_Q16 - t;
		v0 = 96'(p0 ^ COORD_SIGN);
		v1 = 96'(p1 ^ COORD_SIGN);
		v2 = 96'(p2 ^ COORD_SIGN);
		v3 = 96'(p3 ^ COORD_SIGN);
		sw = 96'(s);
		tw = 96'(t);
		if (cubic) begin
			acc = sw * sw * sw * v0 + 96'd3 * sw * sw * tw * v1 + 96'd3 * sw * tw * tw * v2
				+ tw * tw * tw * v3 + (96'd1 << 47);
			acc = acc >> 48;
		end else begin
			// second control point plays no part in a quadratic curve
			acc = sw * sw * v0 + 96'd2 * sw * tw * v1 + tw * tw * v3 + (96'd1 << 31);
			acc = acc >> 32;
		end
		return acc[COORD_W-1:0] ^ COORD_SIGN;
	endfunction

	function automatic void tessellate(input logic [IN_DATA_W-1:0] d);
		logic [COORD_W-1:0] c [NUM_COORDS];
		int                 seg_eff;
		logic [T_W-1:0]     t;
		point_t             p;
		logic               cubic;
		for (int k = 0; k < NUM_COORDS; k++)
			c[k] = d[k*COORD_W +: COORD_W];
		// zero segments behaves as one; six bits cannot exceed the maximum of 63
		seg_eff = (seg_setting == '0) ? 1 : int'(seg_setting);
		cubic = (order_setting == ORDER_CUBIC);
		for (int i = 0; i <= seg_eff; i++) begin
			t      = T_W'((i * int'(ONE_Q16)) / seg_eff);
			p.x    = blend_coord(c[0], c[3], c[6], c[9], t, cubic);
			p.y    = blend_coord(c[1], c[4], c[7], c[10], t, cubic);
			p.z    = blend_coord(c[2], c[5], c[8], c[11], t, cubic);
			p.num  = SEG_W'(i);
			p.last = (i == seg_eff);
			points_due.push_back(p);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_t got, want;
		if (!arst_n) begin
			seg_setting   = SEG_RESET;
			order_setting = ORDER_QUAD;
			bad_points    = 0;
			points_due.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SEGMENTS)
					seg_setting = cfg_data[SEG_W-1:0];
				else if (cfg_index == REG_CURVE_ORDER)
					order_setting = cfg_data[0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.x    = m_axis_tdata[15:0];
				got.y    = m_axis_tdata[31:16];
				got.z    = m_axis_tdata[47:32];
				got.num  = m_axis_tdata[53:48];
				got.last = m_axis_tlast;
				if (points_due.size() == 0) begin
					bad_points++;
					if (bad_points <= 10)
						$display("%0t: point beat with none due: x=%0d y=%0d z=%0d n=%0d last=%0b",
							$realtime, $signed(got.x), $signed(got.y), $signed(got.z),
							got.num, got.last);
				end else begin
					want = points_due.pop_front();
					if (got != want) begin
						bad_points++;
						if (bad_points <= 10) begin
							$write("%0t: point mismatch: expected x=%0d y=%0d z=%0d n=%0d last=%0b,",
								$realtime, $signed(want.x), $signed(want.y), $signed(want.z),
								want.num, want.last);
							$display(" got x=%0d y=%0d z=%0d n=%0d last=%0b",
								$signed(got.x), $signed(got.y), $signed(got.z),
								got.num, got.last);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				tessellate(s_axis_tdata);
			outstanding <= points_due.size();
			mismatches  <= bad_points;
		end
	end

endmodule

### sim/bezier_curve_tessellator_top_tb.sv
// Testbench top for the Bezier curve tessellator: drives curves and register writes,
// stalls the point stream and gives the verdict. Checking lives in the checker module.
// Depends on bct_pkg, bezier_curve_tessellator_top and bezier_curve_tessellator_checker.
module bezier_curve_tessellator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bct_pkg::*;

	localparam int                   STALL_LIMIT = 3000;
	localparam logic [COORD_W-1:0]   CO_MAX      = 16'h7FFF;
	localparam logic [COORD_W-1:0]   CO_MIN      = 16'h8000;
	// unmapped register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic                  m_axis_tlast;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	int                    mismatches;
	int                    outstanding;
	int                    quiet_cycles  = 0;
	bit                    steady        = 1'b0;

	always #2 clk = ~clk;

	bezier_curve_tessellator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	bezier_curve_tessellator_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(99);
		if (r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return CO_MAX;
		if (r < 24)
			return CO_MIN;
		if (r < 30)
			return '0;
		if (r < 34)
			return '1;
		return COORD_W'($urandom);
	endfunction

	function automatic logic [IN_DATA_W-1:0] random_curve();
		logic [IN_DATA_W-1:0] d;
		for (int k = 0; k < NUM_COORDS; k++)
			d[k*COORD_W +: COORD_W] = rand_coord();
		return d;
	endfunction

	// x takes the value, y its inverse, z a scrambled copy
	function automatic logic [IN_DATA_W-1:0] curve_of(
		input logic [COORD_W-1:0] p_start,
		input logic [COORD_W-1:0] p_a,
		input logic [COORD_W-1:0] p_b,
		input logic [COORD_W-1:0] p_finish
	);
		logic [COORD_W-1:0]   v [4];
		logic [IN_DATA_W-1:0] d;
		v[0] = p_start;
		v[1] = p_a;
		v[2] = p_b;
		v[3] = p_finish;
		for (int k = 0; k < 4; k++) begin
			d[(3*k)*COORD_W +: COORD_W]   = v[k];
			d[(3*k+1)*COORD_W +: COORD_W] = ~v[k];
			d[(3*k+2)*COORD_W +: COORD_W] = v[k] ^ 16'h5A5A;
		end
		return d;
	endfunction

	task automatic send_curve(input logic [IN_DATA_W-1:0] d);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait until every predicted point has come out
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic set_mode(input logic [SEG_W-1:0] seg, input logic order);
		logic [CFG_DATA_W-1:0] order_word;
		settle();
		// upper bits of the order word are don't-care
		order_word = {5'($urandom), order};
		if ($urandom_range(1)) begin
			write_reg(REG_SEGMENTS, seg);
			write_reg(REG_CURVE_ORDER, order_word);
		end else begin
			write_reg(REG_CURVE_ORDER, order_word);
			write_reg(REG_SEGMENTS, seg);
		end
	endtask

	// output side: bursts of ready with random stalls between them
	initial begin
		int burst, stall;
		wait (arst_n);
		@(negedge clk);
		forever begin
			burst = $urandom_range(1, 16);
			stall = idle_len();
			m_axis_tready <= 1'b1;
			repeat (burst) @(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [SEG_W-1:0] seg;
		logic             order;
		int               r;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: 60 segments, quadratic
		send_curve(curve_of(CO_MAX, CO_MAX, CO_MAX, CO_MAX));
		send_curve(curve_of(CO_MIN, CO_MAX, '0, CO_MIN));

		// zero segments runs as a single segment
		set_mode('0, ORDER_CUBIC);
		send_curve(curve_of(CO_MIN, CO_MAX, CO_MIN, CO_MAX));
		send_curve(curve_of(CO_MAX, CO_MIN, CO_MAX, CO_MIN));

		// unmapped indexes must leave both registers alone
		settle();
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, '0);
		send_curve(curve_of('0, CO_MAX, CO_MIN, 16'h0001));

		set_mode(6'd63, ORDER_CUBIC);
		send_curve(curve_of(CO_MIN, CO_MIN, CO_MIN, CO_MIN));
		send_curve(curve_of(CO_MAX, CO_MIN, CO_MAX, CO_MIN));

		// second control point is latched but ignored
		set_mode(6'd63, ORDER_QUAD);
		send_curve(curve_of(CO_MAX, CO_MIN, 16'h1234, CO_MAX));
		send_curve(curve_of(CO_MIN, CO_MAX, CO_MAX, CO_MIN));

		set_mode(6'd1, ORDER_QUAD);
		send_curve(random_curve());
		send_curve(random_curve());
		set_mode(6'd2, ORDER_CUBIC);
		send_curve(random_curve());
		set_mode(6'd3, ORDER_QUAD);
		send_curve(random_curve());

		// random phases, mostly short curves
		for (int ph = 0; ph < 10; ph++) begin
			r = $urandom_range(99);
			if (r < 10)
				seg = '0;
			else if (r < 55)
				seg = SEG_W'($urandom_range(1, 8));
			else if (r < 70)
				seg = 6'd63;
			else
				seg = SEG_W'($urandom_range(1, 62));
			order = $urandom_range(1) ? ORDER_CUBIC : ORDER_QUAD;
			set_mode(seg, order);
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
			steady = ($urandom_range(3) == 0);
			repeat (18) send_curve(random_curve());
		end

		steady = 1'b0;
		settle();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
rtl/core/bct_pkg.sv
rtl/core/bct_front.sv
rtl/core/bct_queue.sv
rtl/core/bct_back.sv
rtl/core/bezier_curve_tessellator_top.sv
sim/bezier_curve_tessellator_checker.sv
sim/bezier_curve_tessellator_top_tb.sv
